// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL that carries checks.
// Expects clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is off while reset is asserted
`define P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset
`define P_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/p1305_pkg.sv -----
// Shared types and constants for the Poly1305 MAC unit.
// No dependencies; used by front, queue, core and top level.
package p1305_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_BITS  = BLOCK_BYTES * 8;

  // Input opcodes
  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_PAD    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_R_LOW  = 2'd0;
  localparam logic [1:0] CFG_R_HIGH = 2'd1;
  localparam logic [1:0] CFG_S_LOW  = 2'd2;
  localparam logic [1:0] CFG_S_HIGH = 2'd3;

  // Key clamp for r
  localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  // Work handed from front to core
  typedef struct packed {
    logic                  is_fin;   // emit tag after any block
    logic                  has_blk;  // fold blk into accumulator
    logic                  hibit;    // add 2^128 with the block
    logic [BLOCK_BITS-1:0] blk;
  } job_t;

endpackage

// ----- sv/p1305_front.sv -----
// Front end: takes input words, buffers message bytes, emits block/finish jobs.
// Depends on p1305_pkg.
module p1305_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [63:0]        in_msg_low,
  input  logic [63:0]        in_msg_high,
  input  logic [4:0]         in_byte_count,
  input  logic               q_full,
  output logic               q_push,
  output p1305_pkg::job_t    q_job
);

  logic [127:0] buf_r, buf_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         take;
  logic [4:0]   n_sat;
  logic [4:0]   sum;
  logic [127:0] msg, msg_m, buf_m, comb_lo;
  logic [255:0] sh;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign msg      = {in_msg_high, in_msg_low};
  assign n_sat    = (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;

  // Keep only valid bytes of the message and of the buffer
  always_comb begin
    for (int i = 0; i < p1305_pkg::BLOCK_BYTES; i++) begin
      msg_m[8*i +: 8] = (5'(i) < n_sat) ? msg[8*i +: 8] : 8'h00;
      buf_m[8*i +: 8] = (5'(i) < {1'b0, cnt_r}) ? buf_r[8*i +: 8] : 8'h00;
    end
  end

  // Append new bytes behind the buffered ones
  assign sh      = {128'b0, msg_m} << {cnt_r, 3'b000};
  assign comb_lo = buf_m | sh[127:0];
  assign sum     = {1'b0, cnt_r} + n_sat;

  // Classify the word
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    q_push  = 1'b0;
    q_job   = '0;
    if (take) begin
      case (in_opcode)
        p1305_pkg::OP_ABSORB: begin
          cnt_nxt = sum[3:0];
          buf_nxt = sum[4] ? sh[255:128] : comb_lo;
          if (sum[4]) begin
            q_push        = 1'b1;
            q_job.has_blk = 1'b1;
            q_job.hibit   = 1'b1;
            q_job.blk     = comb_lo;
          end
        end
        p1305_pkg::OP_PAD: begin
          cnt_nxt = 4'd0;
          if (cnt_r != 4'd0) begin
            q_push        = 1'b1;
            q_job.has_blk = 1'b1;
            q_job.hibit   = 1'b1;
            q_job.blk     = buf_m;
          end
        end
        p1305_pkg::OP_FINISH: begin
          cnt_nxt       = 4'd0;
          q_push        = 1'b1;
          q_job.is_fin  = 1'b1;
          q_job.has_blk = (cnt_r != 4'd0);
          q_job.blk     = buf_m | (128'h1 << {cnt_r, 3'b000});
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- sv/p1305_queue.sv -----
// Small job queue between front end and core.
// Depends on p1305_pkg.
module p1305_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  p1305_pkg::job_t push_job,
  input  logic            pop,
  output p1305_pkg::job_t head_job,
  output logic            full,
  output logic            empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  p1305_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign level    = cnt_r;
  assign head_job = mem[rp_r];

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- sv/p1305_core.sv -----
// Core: folds blocks into the accumulator modulo 2^130-5 and makes the tag.
// Depends on p1305_pkg.
module p1305_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  p1305_pkg::job_t q_head,
  output logic            q_pop,
  input  logic [127:0]    key_r,
  input  logic [127:0]    key_s,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     out_tag_low,
  output logic [63:0]     out_tag_high
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RED1 = 3'd3;
  localparam logic [2:0] S_RED2 = 3'd4;
  localparam logic [2:0] S_FIN1 = 3'd5;
  localparam logic [2:0] S_FIN2 = 3'd6;
  localparam logic [2:0] S_FIN3 = 3'd7;

  localparam logic [2:0] LAST_DIGIT = 3'd5;

  logic [2:0]      st_r, st_nxt;
  logic [2:0]      dig_r, dig_nxt;
  p1305_pkg::job_t job_r, job_nxt;
  logic [130:0]    h_r, h_nxt;
  logic [159:0]    a_r, a_nxt;
  logic [255:0]    acc_r, acc_nxt;
  logic [63:0]     p_r [4];
  logic [63:0]     p_nxt [4];
  logic [130:0]    t_r, t_nxt;
  logic [129:0]    hc_r, hc_nxt;
  logic            ov_r, ov_nxt;
  logic [127:0]    tag_r, tag_nxt;

  logic [127:0]    rc;
  logic [159:0]    row;
  logic [125:0]    hi;
  logic [130:0]    g;
  logic            out_free;

  assign rc        = key_r & p1305_pkg::R_CLAMP;
  assign row       = {32'b0, p_r[2], p_r[0]} + {p_r[3], p_r[1], 32'b0};
  assign hi        = acc_r[255:130];
  assign g         = t_r + 131'd5;
  assign out_free  = !ov_r || out_ready;
  assign out_valid    = ov_r;
  assign out_tag_low  = tag_r[63:0];
  assign out_tag_high = tag_r[127:64];

  always_comb begin
    st_nxt  = st_r;
    dig_nxt = dig_r;
    job_nxt = job_r;
    h_nxt   = h_r;
    a_nxt   = a_r;
    acc_nxt = acc_r;
    t_nxt   = t_r;
    hc_nxt  = hc_r;
    tag_nxt = tag_r;
    ov_nxt  = ov_r;
    q_pop   = 1'b0;
    for (int j = 0; j < 4; j++) begin
      p_nxt[j] = p_r[j];
    end
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      // Take the next job
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
          st_nxt  = q_head.has_blk ? S_ADD : S_FIN1;
        end
      end
      // a = h + m (+ 2^128)
      S_ADD: begin
        a_nxt   = {29'b0, h_r + {3'b0, job_r.blk} + {2'b0, job_r.hibit, 128'b0}};
        acc_nxt = '0;
        dig_nxt = 3'd0;
        st_nxt  = S_MUL;
      end
      // One 32-bit digit of a times r per cycle, top digit first
      S_MUL: begin
        if (dig_r != LAST_DIGIT) begin
          for (int j = 0; j < 4; j++) begin
            p_nxt[j] = a_r[159:128] * rc[32*j +: 32];
          end
          a_nxt = a_r << 32;
        end
        if (dig_r != 3'd0) begin
          acc_nxt = (acc_r << 32) + {96'b0, row};
        end
        dig_nxt = dig_r + 3'd1;
        if (dig_r == LAST_DIGIT) begin
          st_nxt = S_RED1;
        end
      end
      // Fold bits above 2^130 back in times 5
      S_RED1: begin
        t_nxt  = {1'b0, acc_r[129:0]} + {5'b0, hi} + {3'b0, hi, 2'b00};
        st_nxt = S_RED2;
      end
      S_RED2: begin
        h_nxt  = {1'b0, t_r[129:0]} + {128'b0, t_r[130], 1'b0, t_r[130]};
        st_nxt = job_r.is_fin ? S_FIN1 : S_IDLE;
      end
      // Final reduction: bring h below 2^130 + 5
      S_FIN1: begin
        t_nxt  = {1'b0, h_r[129:0]} + {128'b0, h_r[130], 1'b0, h_r[130]};
        st_nxt = S_FIN2;
      end
      // Subtract p when h >= p
      S_FIN2: begin
        hc_nxt = g[130] ? g[129:0] : t_r[129:0];
        st_nxt = S_FIN3;
      end
      // Add pad and emit tag
      S_FIN3: begin
        if (out_free) begin
          tag_nxt = hc_r[127:0] + key_s;
          ov_nxt  = 1'b1;
          h_nxt   = '0;
          st_nxt  = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    job_r <= job_nxt;
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    t_r   <= t_nxt;
    hc_r  <= hc_nxt;
    tag_r <= tag_nxt;
    for (int j = 0; j < 4; j++) begin
      p_r[j] <= p_nxt[j];
    end
  end

  // Control state and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      h_r  <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      h_r  <= h_nxt;
    end
  end

endmodule

// ----- sv/poly1305_mac_unit.sv -----
// Top level of the Poly1305 MAC unit: key registers, front end, job queue, core.
// Depends on p1305_pkg, p1305_front, p1305_queue, p1305_core, assert_macros.svh.
//
// Poly1305 authenticator. Write r (indexes 0,1) and s (2,3) on the cfg port, then
// send words: absorb up to 16 bytes, zero-pad the partial block, or finish. Finish
// returns one tag word and clears the message state; the key stays. The front end
// takes a word per cycle while the job queue has room. For each 16-byte block the
// core pops the job, adds, makes five 32-bit digit passes through four 32x32
// multipliers plus a drain step, and runs two reduction steps. Finish then does the
// final reduction, the subtraction of p and the pad addition, after the last
// reduction or, with no partial block, after the pop; the tag goes out once the
// previous one is taken. The core takes no new job before the last is done.
module poly1305_mac_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_msg_low,
  input  logic [63:0] in_msg_high,
  input  logic [4:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_tag_low,
  output logic [63:0] out_tag_high
);

  `include "assert_macros.svh"

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic [63:0] r_low_r, r_high_r, s_low_r, s_high_r;
  logic            q_push, q_pop, q_full, q_empty;
  logic [LW-1:0]   q_level;
  p1305_pkg::job_t q_in, q_head;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r  <= '0;
      r_high_r <= '0;
      s_low_r  <= '0;
      s_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        p1305_pkg::CFG_R_LOW:  r_low_r  <= cfg_wdata;
        p1305_pkg::CFG_R_HIGH: r_high_r <= cfg_wdata;
        p1305_pkg::CFG_S_LOW:  s_low_r  <= cfg_wdata;
        p1305_pkg::CFG_S_HIGH: s_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  p1305_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_msg_low    (in_msg_low),
    .in_msg_high   (in_msg_high),
    .in_byte_count (in_byte_count),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_in)
  );

  p1305_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in),
    .pop      (q_pop),
    .head_job (q_head),
    .full     (q_full),
    .empty    (q_empty),
    .level    (q_level)
  );

  p1305_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .key_r        ({r_high_r, r_low_r}),
    .key_s        ({s_high_r, s_low_r}),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tag_low  (out_tag_low),
    .out_tag_high (out_tag_high)
  );

  // No result is offered right after a reset cycle
  `P_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")
  // Queue occupancy stays within depth
  `P_ASSERT(a_q_level, q_level <= LW'(QUEUE_DEPTH), "queue level above depth")
  // Core pops only a present job
  `P_ASSERT(a_q_pop, q_pop |-> (q_level != '0), "pop from empty queue")
  // A push into a full queue without a pop would lose a job
  `P_ASSERT(a_q_push, (q_push && !q_pop) |-> (q_level != LW'(QUEUE_DEPTH)), "push into full queue")

endmodule
